// ----- rtl/zsfir_pkg.sv -----
// Shared constants and types for the zero-stuffing FIR interpolator.
// No dependencies; imported by the top level and by zsfir_mac.
package zsfir_pkg;

   localparam int TAPS        = 50;
   localparam int DW          = 16;
   localparam int IDX_W       = $clog2(TAPS);
   localparam int ACC_W       = 2 * DW + $clog2(TAPS);
   localparam int FACTOR_W    = 7;
   localparam int FACTOR_MAX  = 64;
   localparam int FACTOR_RST  = 4;
   localparam int CIDX_W      = 6;

   localparam logic FUNC_COEF   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   typedef struct packed {
      logic clr;
      logic dat_vld;
      logic ring_ok;
      logic coef_ok;
   } mac_ctrl_type;

endpackage

// ----- rtl/zero_stuff_fir_interpolator_unit.sv -----
// Top level of the zero-stuffing FIR interpolator: sequencer, stores and ports.
// Depends on zsfir_pkg, zsfir_ram and zsfir_mac.
//
//   channel   direction  transfer moves
//   req_*     in         func, coef_index, coef_value, sample
//   rsp_*     out        out_sample, last
//   csr_*     in         factor register write data
//
// During a sample transfer, each output uses one ring write, TAPS passes
// through the single shared multiplier, a drain and a result step.
// Synchronous reset clears the valid bits of both stores, so they read as zero,
// and sets factor to 4. A result waits while the output register is still full.
module zero_stuff_fir_interpolator_unit
   import zsfir_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_func,
   input  logic [CIDX_W-1:0]   req_coef_index,
   input  logic [DW-1:0]       req_coef_value,
   input  logic [DW-1:0]       req_sample,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [DW-1:0]       rsp_out_sample,
   output logic                rsp_last,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [FACTOR_W-1:0] csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRITE,
      ST_MAC,
      ST_DRAIN,
      ST_FIN
   } state_type;

   state_type            state_ff, state_in;
   logic [FACTOR_W-1:0]  factor_ff, factor_in;
   logic [FACTOR_W-1:0]  k_ff, k_in;
   logic [FACTOR_W-1:0]  nlim_ff, nlim_in;
   logic [DW-1:0]        sample_ff, sample_in;
   logic [IDX_W-1:0]     wpos_ff, wpos_in;
   logic [IDX_W-1:0]     rpos_ff, rpos_in;
   logic [IDX_W-1:0]     tap_ff, tap_in;
   logic [TAPS-1:0]      ring_vld_ff, ring_vld_in;
   logic [TAPS-1:0]      coef_vld_ff, coef_vld_in;
   logic                 s1_ff, s1_in;
   logic                 rok_ff, rok_in;
   logic                 cok_ff, cok_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]        rsp_out_sample_ff, rsp_out_sample_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 req_xfer;
   logic                 coef_wr;
   logic                 ring_wr;
   logic [DW-1:0]        ring_wdata;
   logic                 rd_en;
   logic [DW-1:0]        ring_rdata;
   logic [DW-1:0]        coef_rdata;
   logic                 mac_pend;
   logic [DW-1:0]        mac_result;
   logic                 out_free;
   logic                 is_last;
   logic [IDX_W-1:0]     wpos_nxt;
   logic [IDX_W-1:0]     rpos_nxt;
   mac_ctrl_type         mac_ctrl;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_last   = (k_ff == nlim_ff - 1'b1);
   assign wpos_nxt  = (wpos_ff == IDX_W'(TAPS - 1)) ? '0 : wpos_ff + 1'b1;
   assign rpos_nxt  = (rpos_ff == IDX_W'(TAPS - 1)) ? '0 : rpos_ff + 1'b1;
   assign coef_wr   = req_xfer && (req_func == FUNC_COEF) &&
                      (FACTOR_W'(req_coef_index) < FACTOR_W'(TAPS));
   assign ring_wr   = (state_ff == ST_WRITE);
   assign ring_wdata = (k_ff == '0) ? sample_ff : '0;
   assign rd_en     = (state_ff == ST_MAC);

   assign mac_ctrl.clr     = (state_ff == ST_WRITE);
   assign mac_ctrl.dat_vld = s1_ff;
   assign mac_ctrl.ring_ok = rok_ff;
   assign mac_ctrl.coef_ok = cok_ff;

   always_comb begin
      state_in          = state_ff;
      factor_in         = factor_ff;
      k_in              = k_ff;
      nlim_in           = nlim_ff;
      sample_in         = sample_ff;
      wpos_in           = wpos_ff;
      rpos_in           = rpos_ff;
      tap_in            = tap_ff;
      ring_vld_in       = ring_vld_ff;
      coef_vld_in       = coef_vld_ff;
      s1_in             = 1'b0;
      rok_in            = rok_ff;
      cok_in            = cok_ff;
      rsp_valid_in      = rsp_valid_ff && !rsp_ready;
      rsp_out_sample_in = rsp_out_sample_ff;
      rsp_last_in       = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         factor_in = csr_data;
      end
      if (coef_wr) begin
         coef_vld_in[req_coef_index[IDX_W-1:0]] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_func == FUNC_SAMPLE)) begin
               sample_in = req_sample;
               k_in      = '0;
               if (factor_ff == '0) begin
                  nlim_in = FACTOR_W'(1);
               end else if (factor_ff > FACTOR_W'(FACTOR_MAX)) begin
                  nlim_in = FACTOR_W'(FACTOR_MAX);
               end else begin
                  nlim_in = factor_ff;
               end
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            ring_vld_in[wpos_ff] = 1'b1;
            wpos_in  = wpos_nxt;
            rpos_in  = wpos_nxt;
            tap_in   = '0;
            state_in = ST_MAC;
         end
         ST_MAC: begin
            s1_in   = 1'b1;
            rok_in  = ring_vld_ff[rpos_ff];
            cok_in  = coef_vld_ff[tap_ff];
            rpos_in = rpos_nxt;
            tap_in  = tap_ff + 1'b1;
            if (tap_ff == IDX_W'(TAPS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_ff && !mac_pend) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_out_sample_in = mac_result;
               rsp_last_in       = is_last;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_WRITE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         factor_ff    <= FACTOR_W'(FACTOR_RST);
         wpos_ff      <= '0;
         ring_vld_ff  <= '0;
         coef_vld_ff  <= '0;
         s1_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         factor_ff    <= factor_in;
         wpos_ff      <= wpos_in;
         ring_vld_ff  <= ring_vld_in;
         coef_vld_ff  <= coef_vld_in;
         s1_ff        <= s1_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff              <= k_in;
      nlim_ff           <= nlim_in;
      sample_ff         <= sample_in;
      rpos_ff           <= rpos_in;
      tap_ff            <= tap_in;
      rok_ff            <= rok_in;
      cok_ff            <= cok_in;
      rsp_out_sample_ff <= rsp_out_sample_in;
      rsp_last_ff       <= rsp_last_in;
   end

   zsfir_ram #(
      .WIDTH(DW),
      .DEPTH(TAPS)
   ) u_ring_ram (
      .clock   (clock),
      .wr_en   (ring_wr),
      .wr_addr (wpos_ff),
      .wr_data (ring_wdata),
      .rd_en   (rd_en),
      .rd_addr (rpos_ff),
      .rd_data (ring_rdata)
   );

   zsfir_ram #(
      .WIDTH(DW),
      .DEPTH(TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_wr),
      .wr_addr (req_coef_index[IDX_W-1:0]),
      .wr_data (req_coef_value),
      .rd_en   (rd_en),
      .rd_addr (tap_ff),
      .rd_data (coef_rdata)
   );

   zsfir_mac u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (mac_ctrl),
      .ring_data (ring_rdata),
      .coef_data (coef_rdata),
      .pend      (mac_pend),
      .result    (mac_result)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_sample = rsp_out_sample_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ----- rtl/zsfir_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module zsfir_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/zsfir_mac.sv -----
// Shared multiply-accumulate unit with rounding and saturation of the sum.
// Depends on zsfir_pkg for widths and the control struct.
module zsfir_mac
   import zsfir_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  mac_ctrl_type  ctrl,
   input  logic [DW-1:0] ring_data,
   input  logic [DW-1:0] coef_data,
   output logic          pend,
   output logic [DW-1:0] result
);

   logic signed [2*DW-1:0]  prod_ff;
   logic signed [2*DW-1:0]  prod_in;
   logic                    prod_vld_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic signed [ACC_W-1:0] rnd;
   logic signed [ACC_W-1:0] quo;
   logic                    fits;

   always_comb begin
      if (ctrl.ring_ok && ctrl.coef_ok) begin
         prod_in = $signed(ring_data) * $signed(coef_data);
      end else begin
         prod_in = '0;
      end
      if (ctrl.clr) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.dat_vld;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // Round half up, floor shift, then clamp to the signed output range.
   assign rnd  = acc_ff + (ACC_W'(1) <<< (DW - 2));
   assign quo  = rnd >>> (DW - 1);
   assign fits = (&quo[ACC_W-1:DW-1]) || !(|quo[ACC_W-1:DW-1]);

   assign result = fits ? quo[DW-1:0] : {quo[ACC_W-1], {(DW-1){~quo[ACC_W-1]}}};
   assign pend   = prod_vld_ff;

endmodule
